/* rtl/lswrs_pkg.sv */
`timescale 1ns / 1ps

package lswrs_pkg;

   // Sensor row and field widths
   localparam int NUM_SENSORS = 16;
   localparam int HIT_W       = 16;
   localparam int SCAN_N      = (NUM_SENSORS < HIT_W) ? NUM_SENSORS : HIT_W;
   localparam int IDX_W       = 4;
   localparam int CENTER_W    = 4;
   localparam int GAIN_W      = 8;
   localparam int SERVO_W     = 12;
   localparam int TERM_W      = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_CENTER    = 2'd2;

   // Register reset values
   localparam logic [CENTER_W-1:0] CENTER_POSITION_RST = 4'd7;
   localparam logic [GAIN_W-1:0]   STEER_GAIN_RST      = 8'd1;
   localparam logic [SERVO_W-1:0]  SERVO_CENTER_RST    = 12'd2048;

   localparam logic [SERVO_W-1:0]  SERVO_MAX = 12'd4095;

   typedef logic [HIT_W-1:0] hits_type;
   typedef logic [IDX_W-1:0] idx_type;

endpackage

/* rtl/line_sensor_widest_run_steering.sv */
`timescale 1ns / 1ps

// Line sensor widest-run steering.
// Input: pulse start with req_sensor_hits (one hit bit per sensor); busy stays
// low, so a new snapshot is taken on every cycle that start is high.
// Output: rsp_strobe is high for one cycle with the widest run of hits (a run
// may bridge one missed sensor; on equal width the later run wins), its floor
// midpoint, the proportional steering term and the saturated servo angle.
// rsp_angle_valid is low when the midpoint is zero; the angle is then the
// configured servo center.
// Throughput one snapshot per cycle. The start beat is held in the input
// register; the run search, midpoint and 4x8 multiply sit between the
// input register and the result register, which drives the strobe.
// Config: csr_we/csr_index/csr_wdata write center position (0), gain (1) and
// servo center (2); other indexes are ignored. Write only while idle.
// Reset (synchronous, active high) clears the pipeline valids and loads the
// register defaults (7, 1, 2048). The receiver cannot stall: each result is
// shown for exactly one cycle.
module line_sensor_widest_run_steering (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [lswrs_pkg::HIT_W-1:0]      req_sensor_hits,
   output logic                             rsp_strobe,
   output logic [lswrs_pkg::IDX_W-1:0]      rsp_run_start,
   output logic [lswrs_pkg::IDX_W-1:0]      rsp_run_end,
   output logic [lswrs_pkg::IDX_W-1:0]      rsp_line_middle,
   output logic signed [lswrs_pkg::TERM_W-1:0] rsp_steer_term,
   output logic [lswrs_pkg::SERVO_W-1:0]    rsp_servo_angle,
   output logic                             rsp_angle_valid,
   input  logic                             csr_we,
   input  logic [lswrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lswrs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lswrs_pkg::*;

   // Config registers
   logic [CENTER_W-1:0] center_ff, center_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [SERVO_W-1:0]  servo_ff, servo_in;

   // Input stage
   logic     in_vld_ff, in_vld_in;
   hits_type hits_ff, hits_in;

   // Result stage
   logic                       out_vld_ff, out_vld_in;
   idx_type                    start_ff, start_in;
   idx_type                    end_ff, end_in;
   idx_type                    mid_ff, mid_in;
   logic signed [TERM_W-1:0]   term_ff, term_in;
   logic [SERVO_W-1:0]         angle_ff, angle_in;
   logic                       valid_ff, valid_in;

   // Run search signals
   hits_type   hit_mask, hit, bridged, run_first, run_last, span_mask;
   logic       found;
   idx_type    best_s, best_e;
   logic [IDX_W:0] mid_sum;
   logic signed [CENTER_W:0]        pos_err;
   logic signed [GAIN_W+CENTER_W+1:0] prod;
   logic signed [SERVO_W+1:0]       angle_sum;
   logic [SERVO_W-1:0]              angle_sat;
   int s, w;

   assign busy = 1'b0;

   // Config write
   always_comb begin
      center_in = center_ff;
      gain_in   = gain_ff;
      servo_in  = servo_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CENTER_POSITION: center_in = csr_wdata[CENTER_W-1:0];
            CSR_STEER_GAIN:      gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_SERVO_CENTER:    servo_in  = csr_wdata[SERVO_W-1:0];
            default: ;
         endcase
      end
   end

   // Input capture
   assign in_vld_in = start & ~busy;
   assign hits_in   = (start & ~busy) ? req_sensor_hits : hits_ff;

   // Bridge single misses, then mark run edges
   always_comb begin
      hit_mask  = (SCAN_N >= HIT_W) ? {HIT_W{1'b1}} : ~({HIT_W{1'b1}} << SCAN_N);
      hit       = hits_ff & hit_mask;
      bridged   = hit | (~hit & (hit << 1) & (hit >> 1));
      run_first = bridged & ~(bridged << 1);
      run_last  = bridged & ~(bridged >> 1);
   end

   // Widest run first, later start on a tie
   always_comb begin
      found     = 1'b0;
      best_s    = '0;
      best_e    = '0;
      span_mask = '0;
      for (w = HIT_W - 1; w >= 0; w--) begin
         for (s = HIT_W - 1 - w; s >= 0; s--) begin
            span_mask = ({HIT_W{1'b1}} << s) & ({HIT_W{1'b1}} >> (HIT_W - 1 - s - w));
            if (!found && run_first[s] && run_last[s + w] && ((bridged & span_mask) == span_mask))
            begin
               found  = 1'b1;
               best_s = IDX_W'(s);
               best_e = IDX_W'(s + w);
            end
         end
      end
   end

   // Midpoint, steering term and saturated angle
   always_comb begin
      mid_sum   = {1'b0, best_s} + {1'b0, best_e};
      mid_in    = mid_sum[IDX_W:1];
      pos_err   = $signed({1'b0, center_ff}) - $signed({1'b0, mid_in});
      prod      = pos_err * $signed({1'b0, gain_ff});
      term_in   = prod[TERM_W-1:0];
      angle_sum = $signed({2'b00, servo_ff}) + (SERVO_W+2)'(term_in);
      if (angle_sum < 0) begin
         angle_sat = '0;
      end else if (angle_sum > $signed({2'b00, SERVO_MAX})) begin
         angle_sat = SERVO_MAX;
      end else begin
         angle_sat = angle_sum[SERVO_W-1:0];
      end
      valid_in   = (mid_in != '0);
      angle_in   = valid_in ? angle_sat : servo_ff;
      start_in   = best_s;
      end_in     = best_e;
      out_vld_in = in_vld_ff;
   end

   // Control and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         center_ff  <= CENTER_POSITION_RST;
         gain_ff    <= STEER_GAIN_RST;
         servo_ff   <= SERVO_CENTER_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         center_ff  <= center_in;
         gain_ff    <= gain_in;
         servo_ff   <= servo_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hits_ff <= hits_in;
      if (in_vld_ff) begin
         start_ff <= start_in;
         end_ff   <= end_in;
         mid_ff   <= mid_in;
         term_ff  <= term_in;
         angle_ff <= angle_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe      = out_vld_ff;
   assign rsp_run_start   = start_ff;
   assign rsp_run_end     = end_ff;
   assign rsp_line_middle = mid_ff;
   assign rsp_steer_term  = term_ff;
   assign rsp_servo_angle = angle_ff;
   assign rsp_angle_valid = valid_ff;

   // Every accepted beat yields a result through the input and result registers
   a_beat_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted beat produced no result");

   // No result without an accepted beat
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!in_vld_ff) |=> !rsp_strobe)
      else $error("result without accepted beat");

   // Winning run is ordered and the valid flag tracks the midpoint
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_run_start <= rsp_run_end)
                     && (rsp_angle_valid == (rsp_line_middle != '0)))
      else $error("bad run bounds or angle valid flag");

endmodule
